### sv/ncdf_pkg.sv
// Constants and widths shared by the normal CDF evaluator.
package ncdf_pkg;

    // Magnitude of the score: at most 2^15, fits 16 bits unsigned.
    localparam int MAG_W = 16;
    // Horner accumulator and polynomial value width.
    localparam int HW    = 48;
    // Reciprocal width (Q.31, up to 2^31).
    localparam int QUO_W = 32;
    // 2^55 / q: dividend bits above the quotient seed the remainder.
    localparam int DIVIDEND_LOG2 = 55;

    // Polynomial coefficients in Q.24.
    localparam logic [HW-1:0] COEF_C1 = HW'(3302662);
    localparam logic [HW-1:0] COEF_C2 = HW'(1932635);
    localparam logic [HW-1:0] COEF_C3 = HW'(5771);
    localparam logic [HW-1:0] COEF_C4 = HW'(327609);
    localparam logic [HW-1:0] ONE_Q24 = HW'(64'd1 << 24);

    localparam logic [HW:0] DIV_INIT_REM = (HW+1)'(64'd1 << (DIVIDEND_LOG2 - QUO_W));

endpackage

### sv/ncdf_div.sv
// Pipelined restoring divider: 2^55 / den, one quotient bit per stage.
module ncdf_div
    import ncdf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [HW-1:0]    in_den,
    input  logic             in_tag,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quo,
    output logic             out_tag
);

    localparam int NS = QUO_W;

    logic             v_reg   [NS];
    logic [HW:0]      rem_reg [NS];
    logic [HW-1:0]    den_reg [NS];
    logic [QUO_W-1:0] quo_reg [NS];
    logic             tag_reg [NS];
    logic             en      [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            logic             pv;
            logic [HW:0]      prem;
            logic [HW-1:0]    pden;
            logic [QUO_W-1:0] pquo;
            logic             ptag;
            logic [HW+1:0]    shifted;
            logic [HW+1:0]    diff;
            logic             take;

            if (i == 0) begin : g_first
                assign pv   = in_valid;
                assign prem = DIV_INIT_REM;
                assign pden = in_den;
                assign pquo = '0;
                assign ptag = in_tag;
            end else begin : g_rest
                assign pv   = v_reg[i-1];
                assign prem = rem_reg[i-1];
                assign pden = den_reg[i-1];
                assign pquo = quo_reg[i-1];
                assign ptag = tag_reg[i-1];
            end

            if (i == NS - 1) begin : g_last
                assign en[i] = !v_reg[i] || out_ready;
            end else begin : g_mid
                assign en[i] = !v_reg[i] || en[i+1];
            end

            // dividend bits below 2^55 are zero, so the shift brings in 0
            assign shifted = {prem, 1'b0};
            assign diff    = shifted - {2'b00, pden};
            assign take    = !diff[HW+1];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en[i]) begin
                    v_reg[i] <= pv;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[i] && pv) begin
                    rem_reg[i] <= take ? diff[HW:0] : shifted[HW:0];
                    den_reg[i] <= pden;
                    quo_reg[i] <= {pquo[QUO_W-2:0], take};
                    tag_reg[i] <= ptag;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];

endmodule

### sv/normal_cdf_approximation_top.sv
// Standard normal CDF evaluator, quartic approximation, fully pipelined.
//
// Input stream s_*: one signed Q3.12 score per item in s_tdata.
// Output stream m_*: one unsigned probability per item, PROB_BITS fraction
// bits, all ones where the value would reach 1.0.
// Pipeline: 40 register stages (1 input stage, 4 Horner stages, 32 divider
// stages, 2 squaring stages, 1 output stage).
// Throughput: one item per cycle while m_tready stays high; the 32-stage
// divider retires one quotient bit per stage, so nothing iterates.
// Each stage holds its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up while m_tready is low
// and s_tready stays high until every stage holds an item.
// Reset (aresetn low, synchronous) clears all valid bits; no item in flight
// survives. There is no other state.
// Stalls lose and repeat nothing; m_tdata holds while m_tvalid waits.
module normal_cdf_approximation_top
    import ncdf_pkg::*;
#(
    parameter int Z_FRAC_BITS = 12,
    parameter int PROB_BITS   = 16
)(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [15:0] s_tdata,   // [15:0] z_value
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((PROB_BITS+7)/8)*8-1:0] m_tdata  // [PROB_BITS-1:0] probability
);

    localparam int OUT_W = ((PROB_BITS + 7) / 8) * 8;
    localparam int PW    = HW + MAG_W;

    // input stage
    logic             va_reg;
    logic [MAG_W-1:0] mag_a_reg;
    logic             neg_a_reg;
    // Horner stages
    logic             vh_reg   [4];
    logic [HW-1:0]    h_reg    [4];
    logic [MAG_W-1:0] mag_h_reg[4];
    logic             neg_h_reg[4];
    logic             en_h     [4];
    // squaring and output
    logic             v2_reg, v4_reg, vo_reg;
    logic [QUO_W-1:0] r2_reg, r4_reg;
    logic             neg2_reg, neg4_reg;
    logic [PROB_BITS-1:0] prob_reg;

    logic en_a, en_2, en_4, en_o;
    logic div_in_ready, div_out_valid, div_tag;
    logic [QUO_W-1:0] div_quo;

    assign en_o = !vo_reg || m_tready;
    assign en_4 = !v4_reg || en_o;
    assign en_2 = !v2_reg || en_4;
    assign en_a = !va_reg || en_h[0];
    assign s_tready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en_a) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && s_tvalid) begin
            neg_a_reg <= s_tdata[15];
            mag_a_reg <= s_tdata[15] ? (~s_tdata + 16'd1) : s_tdata;
        end
    end

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_horner
            logic             pv;
            logic [HW-1:0]    pacc;
            logic [MAG_W-1:0] pmag;
            logic             pneg;
            logic [HW-1:0]    coef;
            logic [PW-1:0]    prod;

            if (k == 0) begin : g_first
                assign pv   = va_reg;
                assign pacc = COEF_C4;
                assign pmag = mag_a_reg;
                assign pneg = neg_a_reg;
            end else begin : g_rest
                assign pv   = vh_reg[k-1];
                assign pacc = h_reg[k-1];
                assign pmag = mag_h_reg[k-1];
                assign pneg = neg_h_reg[k-1];
            end

            if (k == 3) begin : g_last
                assign en_h[k] = !vh_reg[k] || div_in_ready;
            end else begin : g_mid
                assign en_h[k] = !vh_reg[k] || en_h[k+1];
            end

            if (k == 0) begin : g_c3
                assign coef = COEF_C3;
            end else if (k == 1) begin : g_c2
                assign coef = COEF_C2;
            end else if (k == 2) begin : g_c1
                assign coef = COEF_C1;
            end else begin : g_one
                assign coef = ONE_Q24;
            end

            assign prod = pacc * pmag;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vh_reg[k] <= 1'b0;
                end else if (en_h[k]) begin
                    vh_reg[k] <= pv;
                end
            end

            always_ff @(posedge aclk) begin
                if (en_h[k] && pv) begin
                    h_reg[k]     <= coef + HW'(prod >> Z_FRAC_BITS);
                    mag_h_reg[k] <= pmag;
                    neg_h_reg[k] <= pneg;
                end
            end
        end
    endgenerate

    ncdf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vh_reg[3]),
        .in_ready  (div_in_ready),
        .in_den    (h_reg[3]),
        .in_tag    (neg_h_reg[3]),
        .out_valid (div_out_valid),
        .out_ready (en_2),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    logic [2*QUO_W-1:0] sq1, sq2;
    logic [PROB_BITS-1:0] tail;
    logic [PROB_BITS-1:0] upper;

    assign sq1  = div_quo * div_quo;
    assign sq2  = r2_reg * r2_reg;
    assign tail = r4_reg[QUO_W-1 -: PROB_BITS];
    assign upper = (tail == '0) ? '1 : (~tail + PROB_BITS'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en_2) v2_reg <= div_out_valid;
            if (en_4) v4_reg <= v2_reg;
            if (en_o) vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_2 && div_out_valid) begin
            r2_reg   <= sq1[2*QUO_W-2:QUO_W-1];
            neg2_reg <= div_tag;
        end
        if (en_4 && v2_reg) begin
            r4_reg   <= sq2[2*QUO_W-2:QUO_W-1];
            neg4_reg <= neg2_reg;
        end
        if (en_o && v4_reg) begin
            prob_reg <= neg4_reg ? tail : upper;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_W'(prob_reg);

    // empty entry stage always takes an item
    a_entry_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !va_reg |-> s_tready) else $error("entry stage empty but not ready");

    // polynomial never drops below one
    a_poly_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vh_reg[3] |-> (h_reg[3] >= ONE_Q24)) else $error("polynomial below one");

    // reciprocal bounded by 2^31
    a_recip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out_valid |-> (div_quo <= (QUO_W'(1) << (QUO_W-1))))
        else $error("reciprocal out of range");

    // tail for a negative score stays at or below one half
    a_neg_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (en_o && v4_reg && neg4_reg) |=> (prob_reg <= (PROB_BITS'(1) << (PROB_BITS-1))))
        else $error("negative score above one half");

endmodule

### tb/sv/normal_cdf_approximation_top_tb.sv
// Self-checking testbench for the streaming normal CDF evaluator.
`timescale 1ns / 100ps

class cdf_scoreboard;
    logic [15:0] prob_q[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // Quartic tail approximation in fixed point, one probability per score.
    function logic [15:0] cdf_of(logic [15:0] z);
        logic [63:0] mag;
        logic [63:0] h;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] r4;
        logic [63:0] tail;
        logic [63:0] p;
        mag = z[15] ? (64'h10000 - {48'd0, z}) : {48'd0, z};
        h = 64'd327609;
        h = 64'd5771 + ((h * mag) >> 12);
        h = 64'd1932635 + ((h * mag) >> 12);
        h = 64'd3302662 + ((h * mag) >> 12);
        q = 64'd16777216 + ((h * mag) >> 12);
        r = (64'd1 << 55) / q;
        r2 = (r * r) >> 31;
        r4 = (r2 * r2) >> 31;
        tail = r4 >> 16;
        if (z[15]) begin
            p = tail;
        end else begin
            p = 64'h10000 - tail;
            if (p >= 64'h10000) p = 64'hFFFF;
        end
        return p[15:0];
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function void note_score(logic [15:0] z);
        prob_q.push_back(cdf_of(z));
    endfunction

    task check_prob(logic [15:0] got);
        logic [15:0] want;
        if (prob_q.size() == 0) begin
            report($sformatf("probability %h with none pending", got));
            return;
        end
        want = prob_q.pop_front();
        if (got !== want) begin
            report($sformatf("probability got %h want %h", got, want));
        end
    endtask
endclass

module normal_cdf_approximation_top_tb;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    bit hold_off = 1'b0;
    logic [15:0] scores[$];
    cdf_scoreboard sb;

    normal_cdf_approximation_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    initial begin
        #20000000;
        $display("normal_cdf_approximation_top test failed");
        $finish;
    end

    // Accepted items are observed at the edge, after drivers settle.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_score(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_prob(m_tdata);
    end

    // Receiver: random stall pattern, quiet stretches, one long hold-off.
    initial begin
        int mode;
        int k;
        mode = 0;
        k = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            k++;
            if (k % 200 == 0) mode = $urandom_range(0, 2);
            if (hold_off) m_tready <= 1'b0;
            else if (mode == 0) m_tready <= 1'b1;
            else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        wait (sb != null);
        repeat (300) @(posedge aclk);
        hold_off = 1'b1;
        repeat (150) @(posedge aclk);
        hold_off = 1'b0;
    end

    task automatic send_scores();
        int gap;
        int burst;
        while (scores.size() > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && scores.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= scores.pop_front();
                @(posedge aclk iff s_tready);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int i;
        int w;
        logic [15:0] v;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // edges: zero, extremes, most negative code, near zero, tails
        scores = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'h0001, 16'hFFFF,
                   16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000,
                   16'h5000, 16'hB000, 16'h0800, 16'hF800, 16'h5555, 16'hAAAA};
        for (i = 0; i < 1400; i++) begin
            w = $urandom_range(0, 3);
            v = 16'($urandom);
            // most items in the useful range |z| < 4, some near zero
            if (w == 0) v = 16'(int'($urandom_range(0, 32767)) - 16384);
            else if (w == 1) v = 16'(int'($urandom_range(0, 2047)) - 1024);
            else if (w == 2) v = 16'(int'($urandom_range(0, 8191)) - 4096);
            scores.push_back(v);
        end
        send_scores();
        while (sb.prob_q.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.prob_q.size() == 0) begin
            $display("normal_cdf_approximation_top test passed");
        end else begin
            $display("normal_cdf_approximation_top test failed");
        end
        $finish;
    end
endmodule
